// ----- design/u8sd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// u8sd_pkg
// Shared types and constants of the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package u8sd_pkg;

    localparam int unsigned CP_W      = 21;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned CNT_W     = 3;
    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;

    localparam logic [CP_W-1:0] REPLACEMENT_RESET = 21'h00FFFD;
    localparam logic [CP_W-1:0] MAX_SCALAR        = 21'h10FFFF;
    localparam logic [CP_W-1:0] SURROGATE_LO      = 21'h00D800;
    localparam logic [CP_W-1:0] SURROGATE_HI      = 21'h00DFFF;
    localparam logic [CP_W-1:0] MIN_TWO_BYTE      = 21'h000080;
    localparam logic [CP_W-1:0] MIN_THREE_BYTE    = 21'h000800;
    localparam logic [CP_W-1:0] MIN_FOUR_BYTE     = 21'h010000;

    // Register index, taken from paddr[2]
    localparam logic REG_REPLACEMENT = 1'b0;

    // Sequence lengths
    localparam logic [CNT_W-1:0] LEN_NONE  = 3'd0;
    localparam logic [CNT_W-1:0] LEN_ONE   = 3'd1;
    localparam logic [CNT_W-1:0] LEN_TWO   = 3'd2;
    localparam logic [CNT_W-1:0] LEN_THREE = 3'd3;
    localparam logic [CNT_W-1:0] LEN_FOUR  = 3'd4;

    // Results caused by one byte: rep_cnt replacements, then optionally a value
    typedef struct packed {
        logic [CNT_W-1:0] rep_cnt;
        logic             has_value;
        logic [CP_W-1:0]  value;
        logic             eot;
    } res_t;

endpackage : u8sd_pkg
`default_nettype wire

// ----- design/u8sd_in_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// u8sd_in_if
// Byte stream channel: one byte of UTF-8 text per transaction.
// ----------------------------------------------------------------------------
interface u8sd_in_if;

    logic                             valid;
    logic                             ready;
    logic [u8sd_pkg::BYTE_W-1:0]      data_byte;
    logic                             end_of_text;

    modport source (output valid, output data_byte, output end_of_text, input ready);
    modport sink   (input valid, input data_byte, input end_of_text, output ready);

endinterface : u8sd_in_if
`default_nettype wire

// ----- design/u8sd_out_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// u8sd_out_if
// Code point channel: one decoded result per transaction.
// ----------------------------------------------------------------------------
interface u8sd_out_if;

    logic                             valid;
    logic                             ready;
    logic [u8sd_pkg::CP_W-1:0]        code_point;
    logic                             replaced;
    logic                             last_of_run;
    logic                             text_done;

    modport source (output valid, output code_point, output replaced,
                    output last_of_run, output text_done, input ready);
    modport sink   (input valid, input code_point, input replaced,
                    input last_of_run, input text_done, output ready);

endinterface : u8sd_out_if
`default_nettype wire

// ----- design/u8sd_cfg_regs.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// u8sd_cfg_regs
// APB register file holding the replacement code point.
// ----------------------------------------------------------------------------
module u8sd_cfg_regs
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [u8sd_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [u8sd_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [u8sd_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                   pready,
    output logic      [u8sd_pkg::CP_W-1:0]         replacement_code
);

    logic [u8sd_pkg::CP_W-1:0] rep_reg;
    logic [u8sd_pkg::CP_W-1:0] rep_next;
    logic                      wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready
                    && (paddr[2] == u8sd_pkg::REG_REPLACEMENT);

    always_comb
    begin
        rep_next = rep_reg;
        if (wr_en)
        begin
            // keep the low 21 bits of the write data
            rep_next = pwdata[u8sd_pkg::CP_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rep_reg <= u8sd_pkg::REPLACEMENT_RESET;
        end
        else
        begin
            rep_reg <= rep_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == u8sd_pkg::REG_REPLACEMENT)
        begin
            prdata = {{(u8sd_pkg::APB_DATA_W - u8sd_pkg::CP_W){1'b0}}, rep_reg};
        end
    end

    assign replacement_code = rep_reg;

endmodule : u8sd_cfg_regs
`default_nettype wire

// ----- design/u8sd_decode.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// u8sd_decode
// Sequence state and single-pass decode of one byte into a result bundle.
// ----------------------------------------------------------------------------
module u8sd_decode
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            accept,
    input  wire logic [u8sd_pkg::BYTE_W-1:0]     data_byte,
    input  wire logic                            end_of_text,
    output u8sd_pkg::res_t                       res
);

    logic [u8sd_pkg::CNT_W-1:0] exp_reg,  exp_next;
    logic [1:0]                 held_reg, held_next;
    logic [u8sd_pkg::CP_W-1:0]  part_reg, part_next;

    logic                       is_cont;
    logic                       fresh;
    logic                       bad;
    logic [u8sd_pkg::CNT_W-1:0] cnt;
    logic [u8sd_pkg::CNT_W-1:0] lead_len;
    logic [u8sd_pkg::CP_W-1:0]  cp;
    logic [u8sd_pkg::CP_W-1:0]  byte_cp;

    assign is_cont = (data_byte[7:6] == 2'b10);
    assign cnt     = {1'b0, held_reg} + 3'd1;
    assign cp      = {part_reg[u8sd_pkg::CP_W-7:0], data_byte[5:0]};
    assign byte_cp = {{(u8sd_pkg::CP_W - u8sd_pkg::BYTE_W){1'b0}}, data_byte};

    always_comb
    begin
        if (!data_byte[7])
            lead_len = u8sd_pkg::LEN_ONE;
        else if (data_byte[7:5] == 3'b110)
            lead_len = u8sd_pkg::LEN_TWO;
        else if (data_byte[7:4] == 4'b1110)
            lead_len = u8sd_pkg::LEN_THREE;
        else if (data_byte[7:3] == 5'b11110)
            lead_len = u8sd_pkg::LEN_FOUR;
        else
            lead_len = u8sd_pkg::LEN_NONE;
    end

    always_comb
    begin
        bad = (cp > u8sd_pkg::MAX_SCALAR)
              || ((cp >= u8sd_pkg::SURROGATE_LO) && (cp <= u8sd_pkg::SURROGATE_HI))
              || ((exp_reg == u8sd_pkg::LEN_TWO)   && (cp < u8sd_pkg::MIN_TWO_BYTE))
              || ((exp_reg == u8sd_pkg::LEN_THREE) && (cp < u8sd_pkg::MIN_THREE_BYTE))
              || ((exp_reg == u8sd_pkg::LEN_FOUR)  && (cp < u8sd_pkg::MIN_FOUR_BYTE));
    end

    always_comb
    begin
        exp_next      = exp_reg;
        held_next     = held_reg;
        part_next     = part_reg;
        fresh         = 1'b1;
        res.rep_cnt   = '0;
        res.has_value = 1'b0;
        res.value     = byte_cp;
        res.eot       = end_of_text;

        if (exp_reg != u8sd_pkg::LEN_NONE)
        begin
            if (is_cont)
            begin
                fresh = 1'b0;
                if (cnt >= exp_reg)
                begin
                    if (bad)
                    begin
                        res.rep_cnt = exp_reg;
                    end
                    else
                    begin
                        res.has_value = 1'b1;
                        res.value     = cp;
                    end
                    exp_next  = u8sd_pkg::LEN_NONE;
                    held_next = '0;
                    part_next = '0;
                end
                else if (end_of_text)
                begin
                    res.rep_cnt = cnt;
                end
                else
                begin
                    held_next = cnt[1:0];
                    part_next = cp;
                end
            end
            else
            begin
                // broken sequence: one replacement per held byte
                res.rep_cnt = {1'b0, held_reg};
                exp_next    = u8sd_pkg::LEN_NONE;
                held_next   = '0;
                part_next   = '0;
            end
        end

        if (fresh)
        begin
            if (lead_len == u8sd_pkg::LEN_NONE)
            begin
                res.rep_cnt = res.rep_cnt + 3'd1;
            end
            else if (lead_len == u8sd_pkg::LEN_ONE)
            begin
                res.has_value = 1'b1;
                res.value     = byte_cp;
            end
            else if (end_of_text)
            begin
                res.rep_cnt = res.rep_cnt + 3'd1;
            end
            else
            begin
                exp_next  = lead_len;
                held_next = 2'd1;
                if (lead_len == u8sd_pkg::LEN_TWO)
                    part_next = {{(u8sd_pkg::CP_W - 5){1'b0}}, data_byte[4:0]};
                else if (lead_len == u8sd_pkg::LEN_THREE)
                    part_next = {{(u8sd_pkg::CP_W - 4){1'b0}}, data_byte[3:0]};
                else
                    part_next = {{(u8sd_pkg::CP_W - 3){1'b0}}, data_byte[2:0]};
            end
        end

        if (end_of_text)
        begin
            exp_next  = u8sd_pkg::LEN_NONE;
            held_next = '0;
            part_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_reg  <= u8sd_pkg::LEN_NONE;
            held_reg <= '0;
            part_reg <= '0;
        end
        else if (accept)
        begin
            exp_reg  <= exp_next;
            held_reg <= held_next;
            part_reg <= part_next;
        end
    end

endmodule : u8sd_decode
`default_nettype wire

// ----- design/u8sd_emit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// u8sd_emit
// Result register: holds one byte's result bundle and hands out its results
// one transaction at a time.
// ----------------------------------------------------------------------------
module u8sd_emit
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        load,
    input  wire u8sd_pkg::res_t              res,
    input  wire logic [u8sd_pkg::CP_W-1:0]   replacement_code,
    output logic                             can_load,
    u8sd_out_if.source                       codes
);

    u8sd_pkg::res_t             res_reg;
    logic [u8sd_pkg::CNT_W-1:0] left_reg, left_next;
    logic [u8sd_pkg::CNT_W-1:0] total;
    logic                       take;
    logic                       is_rep;

    assign total    = res.rep_cnt + {2'b00, res.has_value};
    assign take     = codes.valid && codes.ready;
    assign can_load = (left_reg == 3'd0) || ((left_reg == 3'd1) && codes.ready);

    // replacements go first, the decoded value (if any) is the last result
    assign is_rep = (left_reg > {2'b00, res_reg.has_value});

    always_comb
    begin
        left_next = left_reg;
        if (load)
            left_next = total;
        else if (take)
            left_next = left_reg - 3'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg <= '0;
        end
        else
        begin
            left_reg <= left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign codes.valid       = (left_reg != 3'd0);
    assign codes.code_point  = is_rep ? replacement_code : res_reg.value;
    assign codes.replaced    = is_rep;
    assign codes.last_of_run = (left_reg == 3'd1);
    assign codes.text_done   = (left_reg == 3'd1) && res_reg.eot;

endmodule : u8sd_emit
`default_nettype wire

// ----- design/utf8_stream_decoder_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_stream_decoder_top
// UTF-8 byte stream to code point decoder with per-byte replacement.
//
//   channel       role    transaction
//   byte_stream   sink    data_byte, end_of_text
//   code_stream   source  code_point, replaced, last_of_run, text_done
//   APB           slave   replacement_code at byte address 0
//
// A byte is decoded in the cycle it is accepted and its results (zero to four)
// land in the result register, which hands out one per cycle from the next.
// One byte per cycle is taken while each byte gives at most one result and
// code_stream is ready; more results hold byte_stream until the last is taken.
// Reset closes any open sequence, empties the result register and sets the
// replacement code to U+FFFD. A code_stream stall holds the current result.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_top
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [u8sd_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [u8sd_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [u8sd_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                   pready,
    u8sd_in_if.sink                                byte_stream,
    u8sd_out_if.source                             code_stream
);

    logic [u8sd_pkg::CP_W-1:0] replacement_code;
    logic                      can_load;
    logic                      accept;
    logic                      load;
    u8sd_pkg::res_t            res;

    assign byte_stream.ready = can_load;
    assign accept            = byte_stream.valid && byte_stream.ready;
    // drop bytes that only advance the sequence state
    assign load              = accept && ((res.rep_cnt != '0) || res.has_value);

    u8sd_cfg_regs u_cfg
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .replacement_code (replacement_code)
    );

    u8sd_decode u_decode
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .data_byte   (byte_stream.data_byte),
        .end_of_text (byte_stream.end_of_text),
        .res         (res)
    );

    u8sd_emit u_emit
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .load             (load),
        .res              (res),
        .replacement_code (replacement_code),
        .can_load         (can_load),
        .codes            (code_stream)
    );

endmodule : utf8_stream_decoder_top
`default_nettype wire

// ----- test/u8sd_tb_pkg.sv -----
// ----------------------------------------------------------------------------
// u8sd_tb_pkg
// Decoded text scoreboard for the UTF-8 stream decoder: tracks the open
// sequence and the replacement code, predicts the code points each accepted
// byte yields and checks every code point transaction against them in order.
// ----------------------------------------------------------------------------
package u8sd_tb_pkg;

    import u8sd_pkg::*;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            replaced;
        logic            last_of_run;
        logic            text_done;
    } code_result_t;

    class utf8_scoreboard;

        logic [CP_W-1:0]  repl_code;
        logic [CNT_W-1:0] seq_total;
        int unsigned      seq_taken;
        logic [CP_W-1:0]  seq_bits;
        code_result_t     pending_points[$];
        int unsigned      mismatches;

        function new();
            repl_code = REPLACEMENT_RESET;
            seq_total = LEN_NONE;
            seq_taken = 0;
            seq_bits = '0;
            mismatches = 0;
        endfunction

        function void set_register(logic index, logic [APB_DATA_W-1:0] value);
            if (index == REG_REPLACEMENT)
                repl_code = value[CP_W-1:0];
        endfunction

        function void flag_error(string what, logic [31:0] want, logic [31:0] got);
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch on %s: expected %h, got %h", what, want, got);
        endfunction

        function void emit(logic [CP_W-1:0] cp, logic rep, int unsigned count);
            code_result_t r;
            r = '{code_point: cp, replaced: rep, last_of_run: 1'b0, text_done: 1'b0};
            repeat (count) pending_points = {pending_points, r};
        endfunction

        function void close_sequence();
            seq_total = LEN_NONE;
            seq_taken = 0;
            seq_bits = '0;
        endfunction

        // Predict the code points caused by one accepted byte
        function void take_byte(logic [BYTE_W-1:0] b, logic eot);
            int unsigned      first;
            int unsigned      held_now;
            logic [CP_W-1:0]  cp;
            logic [CNT_W-1:0] lead_len;
            logic [CP_W-1:0]  lead_bits;
            bit               fresh;
            bit               bad;
            code_result_t     tail;
            first = pending_points.size();
            fresh = 1'b1;
            if (seq_total != LEN_NONE)
            begin
                if (b[7:6] == 2'b10)
                begin
                    held_now = seq_taken + 1;
                    cp = {seq_bits[CP_W-7:0], b[5:0]};
                    fresh = 1'b0;
                    if (held_now >= seq_total)
                    begin
                        bad = cp > MAX_SCALAR
                            || (cp >= SURROGATE_LO && cp <= SURROGATE_HI)
                            || (seq_total == LEN_TWO && cp < MIN_TWO_BYTE)
                            || (seq_total == LEN_THREE && cp < MIN_THREE_BYTE)
                            || (seq_total == LEN_FOUR && cp < MIN_FOUR_BYTE);
                        if (bad)
                            emit(repl_code, 1'b1, seq_total);
                        else
                            emit(cp, 1'b0, 1);
                        close_sequence();
                    end
                    else if (eot)
                    begin
                        emit(repl_code, 1'b1, held_now);
                        close_sequence();
                    end
                    else
                    begin
                        seq_taken = held_now;
                        seq_bits = cp;
                    end
                end
                else
                begin
                    // broken sequence: reject what is held, then decode b afresh
                    emit(repl_code, 1'b1, seq_taken);
                    close_sequence();
                end
            end

            if (fresh)
            begin
                casez (b)
                    8'b0???????:
                    begin
                        lead_len = LEN_ONE;
                        lead_bits = CP_W'(b);
                    end
                    8'b110?????:
                    begin
                        lead_len = LEN_TWO;
                        lead_bits = CP_W'(b[4:0]);
                    end
                    8'b1110????:
                    begin
                        lead_len = LEN_THREE;
                        lead_bits = CP_W'(b[3:0]);
                    end
                    8'b11110???:
                    begin
                        lead_len = LEN_FOUR;
                        lead_bits = CP_W'(b[2:0]);
                    end
                    default:
                    begin
                        lead_len = LEN_NONE;
                        lead_bits = '0;
                    end
                endcase
                if (lead_len == LEN_NONE)
                    emit(repl_code, 1'b1, 1);
                else if (lead_len == LEN_ONE)
                    emit(lead_bits, 1'b0, 1);
                else if (eot)
                    emit(repl_code, 1'b1, 1);
                else
                begin
                    seq_total = lead_len;
                    seq_taken = 1;
                    seq_bits = lead_bits;
                end
            end

            if (eot)
                close_sequence();

            if (pending_points.size() > first)
            begin
                tail = pending_points.pop_back();
                tail.last_of_run = 1'b1;
                tail.text_done = eot;
                pending_points = {pending_points, tail};
            end
        endfunction

        // Check one code point transaction against the oldest prediction
        function void match_code_point(logic [CP_W-1:0] cp, logic rep, logic last,
                                       logic done);
            code_result_t want;
            if (pending_points.size() == 0)
            begin
                flag_error("unexpected code point", '0, 32'(cp));
                return;
            end
            want = pending_points.pop_front();
            if (cp !== want.code_point)
                flag_error("code_point", 32'(want.code_point), 32'(cp));
            if (rep !== want.replaced)
                flag_error("replaced", 32'(want.replaced), 32'(rep));
            if (last !== want.last_of_run)
                flag_error("last_of_run", 32'(want.last_of_run), 32'(last));
            if (done !== want.text_done)
                flag_error("text_done", 32'(want.text_done), 32'(done));
        endfunction

    endclass

endpackage : u8sd_tb_pkg

// ----- test/utf8_stream_decoder_top_tb.sv -----
// ----------------------------------------------------------------------------
// utf8_stream_decoder_top_tb
// Drives byte transactions through the UTF-8 stream decoder under random idling on
// both channels: a directed opening covering one-, three- and four-byte sequences
// and every kind of rejection, then random well-formed and broken text under
// several replacement codes set over APB. Every code point transaction is checked.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import u8sd_pkg::*;
    import u8sd_tb_pkg::*;

    localparam int unsigned CYCLE_LIMIT     = 200000;
    localparam int unsigned ITEMS_PER_PHASE = 84;
    localparam int unsigned PHASES          = 5;

    localparam logic [APB_ADDR_W-1:0] REPLACEMENT_ADDR = {REG_REPLACEMENT, 2'b00};
    localparam logic [APB_ADDR_W-1:0] UNMAPPED_ADDR    = 3'd4;

    localparam logic [BYTE_W-1:0] LEAD_TWO   = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD_THREE = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD_FOUR  = 8'hF0;
    localparam logic [BYTE_W-1:0] CONT_MARK  = 8'h80;

    // bit 8 marks the last byte of a text
    localparam logic [8:0] OPENING_TEXT [25] = '{
        9'h000, 9'h17F,                     // ASCII extremes
        9'h0E2, 9'h082, 9'h0AC,             // three-byte sequence
        9'h0F0, 9'h09F, 9'h098, 9'h180,     // four-byte sequence ending the text
        9'h080,                             // stray continuation
        9'h0FF,                             // invalid lead
        9'h0C0, 9'h080,                     // overlong form
        9'h0ED, 9'h0A0, 9'h080,             // surrogate
        9'h0F4, 9'h090, 9'h080, 9'h080,     // above the last scalar value
        9'h0E2, 9'h041,                     // broken sequence
        9'h0E2, 9'h182,                     // cut off by end of text
        9'h1C3                              // lead carrying end of text
    };

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              end_of_text;
    } text_byte_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    int unsigned           cycles = 0;
    bit                    send_burst = 1'b0;
    utf8_scoreboard        text_sb;

    u8sd_in_if  byte_if ();
    u8sd_out_if code_if ();

    utf8_stream_decoder_top u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .byte_stream (byte_if),
        .code_stream (code_if)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic apb_access(input logic write, input logic [APB_ADDR_W-1:0] addr,
                              input logic [APB_DATA_W-1:0] wdata,
                              output logic [APB_DATA_W-1:0] rdata);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= write;
        paddr <= addr;
        pwdata <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        rdata = prdata;
        if (write)
            text_sb.set_register(addr[2], wdata);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_replacement();
        logic [APB_DATA_W-1:0] readback;
        apb_access(1'b0, REPLACEMENT_ADDR, '0, readback);
        if (readback !== APB_DATA_W'(text_sb.repl_code))
            text_sb.flag_error("replacement_code readback", APB_DATA_W'(text_sb.repl_code),
                               readback);
    endtask

    task automatic send_text(input text_byte_t items[$]);
        int unsigned gap;
        foreach (items[i])
        begin
            if ($urandom_range(0, 31) == 0)
                send_burst = !send_burst;
            gap = send_burst ? 0 : $urandom_range(0, 5);
            @(negedge clk);
            if (gap != 0)
            begin
                byte_if.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            byte_if.valid <= 1'b1;
            byte_if.data_byte <= items[i].data_byte;
            byte_if.end_of_text <= items[i].end_of_text;
            do @(posedge clk); while (byte_if.ready !== 1'b1);
            text_sb.take_byte(items[i].data_byte, items[i].end_of_text);
        end
        @(negedge clk);
        byte_if.valid <= 1'b0;
    endtask

    // Hold off until every predicted code point has come, then let the block settle
    task automatic settle_decoder();
        while (text_sb.pending_points.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    // Append one chunk of text: mostly valid sequences, then rejected forms and noise
    function automatic void add_random_text(ref text_byte_t items[$]);
        int unsigned       pick;
        int unsigned       len;
        int unsigned       keep;
        logic [CP_W-1:0]   cp;
        logic [BYTE_W-1:0] lead;
        logic [BYTE_W-1:0] raw[$];
        text_byte_t        tb;
        pick = $urandom_range(0, 99);
        len = 0;
        cp = '0;
        if (pick < 60)
        begin
            len = $urandom_range(1, 4);
            case (len)
                1: cp = CP_W'($urandom_range(0, 'h7F));
                2: cp = CP_W'($urandom_range('h80, 'h7FF));
                3:
                begin
                    cp = CP_W'($urandom_range('h800, 'hFFFF));
                    if (cp >= SURROGATE_LO && cp <= SURROGATE_HI)
                        cp = cp ^ CP_W'('h1000);
                end
                default: cp = CP_W'($urandom_range('h10000, 'h10FFFF));
            endcase
        end
        else if (pick < 68)
        begin
            len = $urandom_range(2, 4);
            cp = CP_W'($urandom_range(0, len == 2 ? 'h7F : len == 3 ? 'h7FF : 'hFFFF));
        end
        else if (pick < 74)
        begin
            len = 3;
            cp = CP_W'($urandom_range(SURROGATE_LO, SURROGATE_HI));
        end
        else if (pick < 80)
        begin
            len = 4;
            cp = CP_W'($urandom_range('h110000, 'h1FFFFF));
        end
        else if (pick < 86)
            repeat ($urandom_range(1, 3)) raw = {raw, BYTE_W'($urandom_range('h80, 'hBF))};
        else if (pick < 90)
            raw = {raw, BYTE_W'($urandom_range('hF8, 'hFF))};
        else
            raw = {raw, BYTE_W'($urandom_range(0, 255))};

        if (len == 1)
            raw = {raw, cp[7:0]};
        else if (len > 1)
        begin
            lead = len == 2 ? LEAD_TWO : len == 3 ? LEAD_THREE : LEAD_FOUR;
            raw = {raw, lead | BYTE_W'(cp >> (6 * (len - 1)))};
            for (int k = len - 1; k > 0; k--)
                raw = {raw, CONT_MARK | BYTE_W'((cp >> (6 * (k - 1))) & CP_W'('h3F))};
            // drop the tail now and then: broken by the next chunk or cut off
            if ($urandom_range(0, 5) == 0)
            begin
                keep = $urandom_range(1, len - 1);
                while (raw.size() > keep)
                    void'(raw.pop_back());
            end
        end

        foreach (raw[i])
        begin
            tb.data_byte = raw[i];
            tb.end_of_text = (i == raw.size() - 1) && ($urandom_range(0, 7) == 0);
            items = {items, tb};
        end
    endfunction

    initial
    begin
        bit          burst;
        int unsigned stall;
        burst = 1'b0;
        code_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 31) == 0)
                burst = !burst;
            stall = burst ? 0 : $urandom_range(0, 5);
            @(negedge clk);
            if (stall != 0)
            begin
                code_if.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            code_if.ready <= 1'b1;
            do @(posedge clk); while (code_if.valid !== 1'b1);
            text_sb.match_code_point(code_if.code_point, code_if.replaced,
                                     code_if.last_of_run, code_if.text_done);
        end
    end

    initial
    begin
        text_byte_t            stimulus[$];
        text_byte_t            tb;
        logic [APB_DATA_W-1:0] unused_rdata;
        logic [CP_W-1:0]       setting;
        int unsigned           failures;
        text_sb = new();
        byte_if.valid = 1'b0;
        byte_if.data_byte = '0;
        byte_if.end_of_text = 1'b0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        check_replacement();
        foreach (OPENING_TEXT[i])
        begin
            tb.data_byte = OPENING_TEXT[i][7:0];
            tb.end_of_text = OPENING_TEXT[i][8];
            stimulus = {stimulus, tb};
        end
        send_text(stimulus);
        settle_decoder();

        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0: setting = '0;
                1: setting = MAX_SCALAR;
                3: setting = REPLACEMENT_RESET;
                default: setting = CP_W'($urandom_range(0, MAX_SCALAR));
            endcase
            apb_access(1'b1, REPLACEMENT_ADDR, APB_DATA_W'(setting), unused_rdata);
            // a write outside the register map must leave the code alone
            if (phase == 3)
                apb_access(1'b1, UNMAPPED_ADDR, $urandom, unused_rdata);
            check_replacement();
            stimulus.delete();
            while (stimulus.size() < ITEMS_PER_PHASE)
                add_random_text(stimulus);
            send_text(stimulus);
            settle_decoder();
        end

        failures = text_sb.mismatches + text_sb.pending_points.size();
        if (failures == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule : utf8_stream_decoder_top_tb
